[rtl/core/msd_pkg.sv]
// Shared constants and character-class helpers for the mangled symbol decoder.
package msd_pkg;

    localparam int DEF_CODED_DEPTH = 64;
    localparam int DEF_LEN_WIDTH   = 16;
    // At most this many character results per input byte; the done result comes on top.
    localparam int CHAR_LIMIT      = 33;
    localparam int ANON_LEN        = 9;

    localparam logic [7:0] CH_US  = 8'h5F;
    localparam logic [7:0] CH_O   = 8'h4F;
    localparam logic [7:0] CH_N   = 8'h4E;
    localparam logic [7:0] CH_U   = 8'h75;
    localparam logic [7:0] CH_A   = 8'h41;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_LA  = 8'h61;

    localparam logic [4:0] BASE_DEC = 5'd10;
    localparam logic [4:0] BASE_26  = 5'd26;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_lhex(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = is_digit(c) ? (c - CH_0) : (c - CH_LA + 8'd10);
        return d[3:0];
    endfunction

    // Text produced for an anonymous symbol.
    function automatic logic [7:0] anon_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h61;
            4'd1:    ch = 8'h6E;
            4'd2:    ch = 8'h6F;
            4'd3:    ch = 8'h6E;
            4'd4:    ch = 8'h79;
            4'd5:    ch = 8'h6D;
            4'd6:    ch = 8'h6F;
            4'd7:    ch = 8'h75;
            4'd8:    ch = 8'h73;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

[rtl/core/mangled_symbol_decoder_unit.sv]
// Top level of the mangled symbol decoder: parser, coded-text buffer and output register.
//
// The slave channel takes one symbol byte per transfer, tlast on the final byte.
// The master channel gives one result per transfer: a decoded character
// (tuser[0] set), or on the final byte a done result (tlast set) whose tuser[1]
// says the symbol was invalid and all its characters must be dropped.
// Each byte is worked on alone: ready drops for the byte and rises again when
// its work is finished. A plain byte passes through SQ_IDLE, SQ_CONSUME and
// SQ_END, a byte that follows an error skips SQ_CONSUME, and the done result is
// issued from SQ_END, held back only while the receiver stalls. The closing
// underscore of a u segment and the last byte of a raw chunk start a walk over the
// coded buffer through a single registered read port: SQ_PN_START and SQ_PN_DIG for
// each chunk length, SQ_HX_START, SQ_HX_HI and SQ_HX_LO for each hex pair, so the
// length of that walk follows from the coded text. Every base-26 digit, and every
// decimal length digit after the first, passes through one shared multiply-add unit.
// A stalled receiver holds the output register and so stalls the parser; a stall
// drops no result. Reset (synchronous, active low) returns the parser to the
// start of a symbol and empties the output register; the coded buffer needs no clearing.
module mangled_symbol_decoder_unit #(
    parameter int CODED_DEPTH = msd_pkg::DEF_CODED_DEPTH,
    parameter int LEN_WIDTH   = msd_pkg::DEF_LEN_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_char
    input  logic       i_s_tlast,   // in_last
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_char
    output logic [1:0] o_m_tuser,   // [0] char_valid, [1] failed
    output logic       o_m_tlast    // done_res
);
    import msd_pkg::*;

    localparam int LW = LEN_WIDTH;
    localparam int MW = LEN_WIDTH + 6;
    localparam int PW = $clog2(CODED_DEPTH + 1);
    localparam int AW = $clog2(CODED_DEPTH);
    localparam logic [MW-1:0] LEN_MASK = MW'({LEN_WIDTH{1'b1}});

    typedef enum logic [3:0] {
        PH_PRE_US, PH_PRE_O, PH_KIND, PH_SEG, PH_PLAIN_LEN, PH_PLAIN_BODY,
        PH_U_LEN0, PH_U_LEN, PH_U_CODED, PH_U_RAW, PH_TAIL
    } t_phase;

    typedef enum logic [3:0] {
        SQ_IDLE, SQ_CONSUME, SQ_ANON, SQ_PN_START, SQ_PN_DIG,
        SQ_HX_START, SQ_HX_HI, SQ_HX_LO, SQ_FINISH, SQ_END
    } t_seq;

    t_seq    r_seq, n_seq;
    t_phase  r_phase, n_phase;
    logic [LW:0]   r_acc, n_acc;
    logic [LW-1:0] r_seg, n_seg;
    logic [LW-1:0] r_chunk, n_chunk;
    logic [LW-1:0] r_raw, n_raw;
    logic [PW-1:0] r_count, n_count;
    logic [PW-1:0] r_pos, n_pos;
    logic          r_any, n_any;
    logic          r_err, n_err;
    logic          r_dig, n_dig;
    logic [3:0]    r_hi, n_hi;
    logic [3:0]    r_idx, n_idx;
    logic [5:0]    r_nres;
    logic [7:0]    r_c;
    logic          r_last;
    logic          r_ov;
    logic [7:0]    r_od;
    logic          r_ochar, r_ofail, r_olast;

    logic [7:0]    mem [CODED_DEPTH];
    logic [7:0]    r_rd;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_lo;

    logic          do_emit, do_done, done_fail;
    logic [7:0]    emit_ch;
    logic          out_free, char_ok, emit_ok;

    logic [4:0]    mul_fac, mul_dig;
    logic [7:0]    dig_dec, dig_up;
    logic [MW-1:0] mul_out;
    logic          mul_ovf;
    logic [LW:0]   sat26;

    logic [LW-1:0] cb_seg, cb_dec;
    logic [PW-1:0] cb_cnt;
    logic          pair_left;

    // Shared multiply-add unit: decimal digits in the parser, base-26 digits in the walk.
    assign dig_dec = r_c - CH_0;
    assign dig_up  = r_rd - CH_A;
    assign mul_fac = (r_seq == SQ_PN_DIG) ? BASE_26 : BASE_DEC;
    assign mul_dig = (r_seq == SQ_PN_DIG) ? dig_up[4:0] : dig_dec[4:0];
    assign mul_out = MW'(r_acc) * MW'(mul_fac) + MW'(mul_dig);
    assign mul_ovf = mul_out > LEN_MASK;
    assign sat26   = mul_ovf ? ((LW+1)'(1) << LW) : mul_out[LW:0];

    // Base values for a coded byte: the first one comes straight after the length.
    assign cb_seg    = (r_phase == PH_U_LEN) ? r_acc[LW-1:0] : r_seg;
    assign cb_cnt    = (r_phase == PH_U_LEN) ? '0 : r_count;
    assign cb_dec    = cb_seg - LW'(1);
    assign pair_left = ((PW+1)'(r_pos) + (PW+1)'(1)) < (PW+1)'(r_count);

    assign out_free = !r_ov || i_m_tready;
    assign char_ok  = r_nres < 6'(CHAR_LIMIT);
    assign emit_ok  = !char_ok || out_free;

    // Sequencer and parser next-state logic.
    always_comb begin
        n_seq = r_seq;     n_phase = r_phase; n_acc = r_acc;   n_seg = r_seg;
        n_chunk = r_chunk; n_raw = r_raw;     n_count = r_count; n_pos = r_pos;
        n_any = r_any;     n_err = r_err;     n_dig = r_dig;   n_hi = r_hi;
        n_idx = r_idx;
        do_emit = 1'b0;  emit_ch = '0;  do_done = 1'b0;
        done_fail = !(!r_err && ((r_phase == PH_SEG) || (r_phase == PH_TAIL)));
        wr_en = 1'b0;    wr_addr = cb_cnt[AW-1:0];  rd_lo = 1'b0;

        case (r_seq)
            SQ_IDLE: begin
                if (i_s_tvalid) begin
                    n_seq = r_err ? SQ_END : SQ_CONSUME;
                end
            end
            SQ_CONSUME: begin
                n_seq = SQ_END;
                case (r_phase)
                    PH_PRE_US: begin
                        if (r_c == CH_US) n_phase = PH_PRE_O; else n_err = 1'b1;
                    end
                    PH_PRE_O: begin
                        if (r_c == CH_O) n_phase = PH_KIND; else n_err = 1'b1;
                    end
                    PH_KIND: begin
                        if (r_c == CH_N) begin
                            n_phase = PH_SEG;
                        end else if (r_c == CH_A) begin
                            n_idx = '0;
                            n_seq = SQ_ANON;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    PH_SEG: begin
                        if (r_c == CH_US) begin
                            n_phase = PH_TAIL;
                        end else if (r_c != CH_U && !is_digit(r_c)) begin
                            n_err = 1'b1;
                        end else if (!r_any || emit_ok) begin
                            if (r_any) begin
                                do_emit = 1'b1;
                                emit_ch = CH_DOT;
                            end
                            if (r_c == CH_U) begin
                                n_acc = '0;
                                n_phase = PH_U_LEN0;
                            end else begin
                                n_acc = (LW+1)'(dig_dec[3:0]);
                                n_phase = PH_PLAIN_LEN;
                            end
                        end else begin
                            n_seq = SQ_CONSUME;
                        end
                    end
                    PH_PLAIN_LEN: begin
                        if (is_digit(r_c)) begin
                            if (mul_ovf) n_err = 1'b1; else n_acc = mul_out[LW:0];
                        end else if (r_acc == '0) begin
                            n_err = 1'b1;
                        end else if (emit_ok) begin
                            do_emit = 1'b1;
                            emit_ch = r_c;
                            n_seg = r_acc[LW-1:0] - LW'(1);
                            n_phase = (n_seg == '0) ? PH_SEG : PH_PLAIN_BODY;
                        end else begin
                            n_seq = SQ_CONSUME;
                        end
                    end
                    PH_PLAIN_BODY: begin
                        if (emit_ok) begin
                            do_emit = 1'b1;
                            emit_ch = r_c;
                            n_seg = r_seg - LW'(1);
                            n_phase = (n_seg == '0) ? PH_SEG : PH_PLAIN_BODY;
                        end else begin
                            n_seq = SQ_CONSUME;
                        end
                    end
                    PH_U_LEN0: begin
                        if (is_digit(r_c)) begin
                            n_acc = (LW+1)'(dig_dec[3:0]);
                            n_phase = PH_U_LEN;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    PH_U_LEN, PH_U_CODED: begin
                        if (r_phase == PH_U_LEN && is_digit(r_c)) begin
                            if (mul_ovf) n_err = 1'b1; else n_acc = mul_out[LW:0];
                        end else if (r_phase == PH_U_LEN && r_acc == '0) begin
                            n_err = 1'b1;
                        end else begin
                            // One coded byte: either the underscore or text for the buffer.
                            n_seg = cb_dec;
                            n_count = cb_cnt;
                            if (r_phase == PH_U_LEN) n_pos = '0;
                            if (r_c == CH_US) begin
                                n_raw = cb_dec;
                                n_chunk = '0;
                                n_pos = '0;
                                n_phase = PH_U_RAW;
                                n_seq = SQ_PN_START;
                            end else if (cb_cnt >= PW'(CODED_DEPTH)) begin
                                n_err = 1'b1;
                            end else begin
                                wr_en = 1'b1;
                                n_count = cb_cnt + PW'(1);
                                n_phase = PH_U_CODED;
                                if (cb_dec == '0) n_err = 1'b1;
                            end
                        end
                    end
                    PH_U_RAW: begin
                        if (emit_ok) begin
                            do_emit = 1'b1;
                            emit_ch = r_c;
                            if (r_raw != '0) n_raw = r_raw - LW'(1);
                            n_seq = SQ_FINISH;
                            if (r_chunk != '0) begin
                                n_chunk = r_chunk - LW'(1);
                                if (r_chunk == LW'(1)) n_seq = SQ_HX_START;
                            end
                        end else begin
                            n_seq = SQ_CONSUME;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            SQ_ANON: begin
                if (emit_ok) begin
                    do_emit = 1'b1;
                    emit_ch = anon_char(r_idx);
                    n_idx = r_idx + 4'd1;
                    if (r_idx == 4'(ANON_LEN - 1)) begin
                        n_phase = PH_TAIL;
                        n_seq = SQ_END;
                    end
                end
            end
            // Walk over the coded buffer: one chunk length.
            SQ_PN_START: begin
                if (r_pos >= r_count) begin
                    n_seq = SQ_FINISH;
                end else begin
                    n_acc = '0;
                    n_dig = 1'b0;
                    n_seq = SQ_PN_DIG;
                end
            end
            SQ_PN_DIG: begin
                if (r_pos < r_count && is_upper(r_rd)) begin
                    n_acc = sat26;
                    n_pos = r_pos + PW'(1);
                    n_dig = 1'b1;
                end else if (!r_dig || r_acc > (LW+1)'(r_raw)) begin
                    n_err = 1'b1;
                    n_seq = SQ_END;
                end else begin
                    n_chunk = r_acc[LW-1:0];
                    n_seq = (r_acc != '0) ? SQ_FINISH : SQ_HX_START;
                end
            end
            // Hex pairs that follow a chunk.
            SQ_HX_START: begin
                n_seq = pair_left ? SQ_HX_HI : SQ_PN_START;
            end
            SQ_HX_HI: begin
                if (!is_lhex(r_rd)) begin
                    n_seq = SQ_PN_START;
                end else begin
                    n_hi = hex_val(r_rd);
                    rd_lo = 1'b1;
                    n_seq = SQ_HX_LO;
                end
            end
            SQ_HX_LO: begin
                if (!is_lhex(r_rd)) begin
                    n_err = 1'b1;
                    n_seq = SQ_END;
                end else if (emit_ok) begin
                    do_emit = 1'b1;
                    emit_ch = {r_hi, hex_val(r_rd)};
                    n_pos = r_pos + PW'(2);
                    n_seq = SQ_HX_START;
                end else begin
                    rd_lo = 1'b1;
                end
            end
            SQ_FINISH: begin
                if (!r_err && r_raw == '0 && r_chunk == '0 && r_pos >= r_count) begin
                    n_phase = PH_SEG;
                end
                n_seq = SQ_END;
            end
            SQ_END: begin
                if (!r_last) begin
                    n_seq = SQ_IDLE;
                end else if (out_free) begin
                    do_done = 1'b1;
                    n_seq = SQ_IDLE;
                    n_phase = PH_PRE_US; n_acc = '0; n_seg = '0; n_chunk = '0;
                    n_raw = '0; n_count = '0; n_pos = '0; n_any = 1'b0; n_err = 1'b0;
                end
            end
            default: begin
                n_seq = SQ_IDLE;
            end
        endcase

        if (do_emit) n_any = 1'b1;
        rd_addr = rd_lo ? (r_pos[AW-1:0] + AW'(1)) : n_pos[AW-1:0];
    end

    // Coded-text buffer with a registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= r_c;
        r_rd <= mem[rd_addr];
    end

    // State, parser registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= SQ_IDLE;  r_phase <= PH_PRE_US; r_acc <= '0;  r_seg <= '0;
            r_chunk <= '0;     r_raw <= '0;          r_count <= '0; r_pos <= '0;
            r_any <= 1'b0;     r_err <= 1'b0;        r_dig <= 1'b0; r_idx <= '0;
            r_nres <= '0;      r_last <= 1'b0;       r_ov <= 1'b0;
        end else begin
            r_seq <= n_seq;    r_phase <= n_phase;   r_acc <= n_acc; r_seg <= n_seg;
            r_chunk <= n_chunk; r_raw <= n_raw;      r_count <= n_count; r_pos <= n_pos;
            r_any <= n_any;    r_err <= n_err;       r_dig <= n_dig; r_idx <= n_idx;
            if (r_seq == SQ_IDLE && i_s_tvalid) begin
                r_nres <= '0;
                r_last <= i_s_tlast;
            end else if (do_emit && char_ok) begin
                r_nres <= r_nres + 6'd1;
            end
            if ((do_emit && char_ok) || do_done) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
        if (r_seq == SQ_IDLE && i_s_tvalid) r_c <= i_s_tdata;
        r_hi <= n_hi;
        if (do_emit && char_ok) begin
            r_od <= emit_ch; r_ochar <= 1'b1; r_ofail <= 1'b0; r_olast <= 1'b0;
        end else if (do_done) begin
            r_od <= '0; r_ochar <= 1'b0; r_ofail <= done_fail; r_olast <= 1'b1;
        end
    end

    assign o_s_tready = (r_seq == SQ_IDLE);
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_od;
    assign o_m_tuser  = {r_ofail, r_ochar};
    assign o_m_tlast  = r_olast;

endmodule

[rtl/core/msd_checker.sv]
// Port-level checks for the mangled symbol decoder, bound to its top level.
module msd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic [1:0] o_m_tuser,
    input logic       o_m_tlast
);

    // A stalled result holds its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // The block works on one byte at a time.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("byte taken while the previous one is in work");

    // A character result is never a done result and never carries failure.
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> !o_m_tlast && !o_m_tuser[1])
        else $error("character result with done or failure set");

    // A done result carries no character.
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> !o_m_tuser[0] && (o_m_tdata == 8'h00))
        else $error("done result carries a character");

endmodule

bind mangled_symbol_decoder_unit msd_checker u_msd_checker (.*);
